// File: rtl/pbcw_pkg.sv
// Shared types and constants for the pileup base-count window.
`timescale 1ns / 1ps
package pbcw_pkg;

    localparam int WINDOW_LOG2_DEF = 10;
    localparam int COUNT_BITS_DEF  = 16;

    localparam logic [1:0] OP_OBSERVE = 2'd0;
    localparam logic [1:0] OP_READ_END = 2'd1;
    localparam logic [1:0] OP_RETIRE  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BEFORE    = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_END_ZERO  = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    localparam logic [2:0] BASE_N    = 3'd4;
    localparam logic [2:0] REF_UNSET = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] position;
        logic [2:0]  ref_base;
        logic [2:0]  alt_base;
        logic [7:0]  quality;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_position;
        logic [2:0]  out_ref_base;
        logic [15:0] depth;
        logic [15:0] end_count;
        logic [15:0] low_quality_count;
        logic [15:0] ref_match_count;
        logic [15:0] count_a;
        logic [15:0] count_c;
        logic [15:0] count_g;
        logic [15:0] count_t;
        logic [15:0] count_n;
    } out_word_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic update;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_sts_t;

endpackage

// File: rtl/pbcw_datapath.sv
// Datapath: slot memory, window pointers and the read-modify-write of one slot.
`timescale 1ns / 1ps
module pbcw_datapath
    import pbcw_pkg::*;
#(
    parameter int WINDOW_LOG2 = WINDOW_LOG2_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  dp_cmd_t   cmd,
    output dp_sts_t   sts,
    input  in_word_t  s_data,
    input  logic      cfg_we,
    input  logic [7:0] cfg_data,
    output out_word_t m_data
);

    localparam int WL = WINDOW_LOG2;
    localparam int CB = COUNT_BITS;
    localparam int WIN = 1 << WL;

    typedef struct packed {
        logic [2:0]         ref_base;
        logic [CB-1:0]      depth;
        logic [CB-1:0]      ends;
        logic [CB-1:0]      low_q;
        logic [CB-1:0]      ref_match;
        logic [4:0][CB-1:0] alt;
    } slot_t;

    localparam slot_t SLOT_CLEAR = '{ref_base: REF_UNSET, default: '0};

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (v == {CB{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] to16(input logic [CB-1:0] v);
        logic [CB+15:0] e;
        e = {16'd0, v};
        return e[15:0];
    endfunction

    slot_t mem [WIN];
    slot_t rdata_reg;

    logic [WL-1:0] head_reg, head_next;
    logic [WL-1:0] tail_reg, tail_next;
    logic [31:0]   ws_reg, ws_next;
    logic [7:0]    cutoff_reg;
    logic [WL:0]   clr_cnt_reg;
    in_word_t      item_reg;
    out_word_t     out_reg, out_next;

    logic [WL-1:0] size, eoff, idx;
    logic [31:0]   off;
    logic          empty, pos_below;
    logic [2:0]    rb, ab;
    logic          upd_we;
    slot_t         wdata, s;

    assign size      = tail_reg - head_reg;
    assign empty     = (size == '0);
    assign off       = item_reg.position - ws_reg;
    assign pos_below = item_reg.position < ws_reg;
    // retire always works on the head slot
    assign eoff      = (empty || item_reg.opcode == OP_RETIRE) ? '0 : off[WL-1:0];
    assign idx       = head_reg + eoff;
    assign rb        = (item_reg.ref_base > BASE_N) ? BASE_N : item_reg.ref_base;
    assign ab        = (item_reg.alt_base > BASE_N) ? BASE_N : item_reg.alt_base;

    always_comb begin
        out_next = '0;
        out_next.status = ST_OK;
        out_next.out_position = item_reg.position;
        out_next.out_ref_base = REF_UNSET;
        head_next = head_reg;
        tail_next = tail_reg;
        ws_next = ws_reg;
        upd_we = 1'b0;
        s = rdata_reg;
        wdata = rdata_reg;
        unique case (item_reg.opcode)
            OP_OBSERVE: begin
                if (!empty && pos_below) begin
                    out_next.status = ST_BEFORE;
                end else if (!empty && off >= 32'(WIN - 1)) begin
                    out_next.status = ST_OVERFLOW;
                end else begin
                    if (empty) ws_next = item_reg.position;
                    s.ref_base = rb;
                    s.depth = sat_inc(rdata_reg.depth);
                    if (item_reg.quality > cutoff_reg) begin
                        if (ab == rb) begin
                            s.ref_match = sat_inc(rdata_reg.ref_match);
                        end else begin
                            for (int b = 0; b < 5; b++) begin
                                if (ab == 3'(b)) s.alt[b] = sat_inc(rdata_reg.alt[b]);
                            end
                        end
                    end else begin
                        s.low_q = sat_inc(rdata_reg.low_q);
                    end
                    if (empty || off >= 32'(size)) tail_next = head_reg + eoff + 1'b1;
                    wdata = s;
                    upd_we = 1'b1;
                end
            end
            OP_READ_END: begin
                if (empty) begin
                    ws_next = item_reg.position;
                    out_next.status = ST_END_ZERO;
                end else if (pos_below) begin
                    out_next.status = ST_BEFORE;
                end else if (off >= 32'(size) || rdata_reg.depth == '0) begin
                    out_next.status = ST_END_ZERO;
                end else begin
                    s.depth = rdata_reg.depth - 1'b1;
                    s.ends = sat_inc(rdata_reg.ends);
                    wdata = s;
                    upd_we = 1'b1;
                end
            end
            OP_RETIRE: begin
                if (empty) begin
                    out_next.status = ST_EMPTY;
                    out_next.out_position = '0;
                end else begin
                    out_next.out_position = ws_reg;
                    wdata = SLOT_CLEAR;
                    upd_we = 1'b1;
                    head_next = head_reg + 1'b1;
                    ws_next = ws_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
        // report the updated slot, or the old one on retire
        if (upd_we) begin
            if (item_reg.opcode == OP_RETIRE) s = rdata_reg;
            out_next.out_ref_base = s.ref_base;
            out_next.depth = to16(s.depth);
            out_next.end_count = to16(s.ends);
            out_next.low_quality_count = to16(s.low_q);
            out_next.ref_match_count = to16(s.ref_match);
            out_next.count_a = to16(s.alt[0]);
            out_next.count_c = to16(s.alt[1]);
            out_next.count_g = to16(s.alt[2]);
            out_next.count_t = to16(s.alt[3]);
            out_next.count_n = to16(s.alt[4]);
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[idx];
        if (cmd.clear_step) begin
            mem[clr_cnt_reg[WL-1:0]] <= SLOT_CLEAR;
        end else if (cmd.update && upd_we) begin
            mem[idx] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) item_reg <= s_data;
        if (cmd.update) out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            ws_reg      <= '0;
            cutoff_reg  <= '0;
            clr_cnt_reg <= '0;
        end else begin
            if (cfg_we) cutoff_reg <= cfg_data;
            if (cmd.clear_step) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.update) begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                ws_reg   <= ws_next;
            end
        end
    end

    assign sts.clear_last = (clr_cnt_reg == (WL+1)'(WIN - 1));
    assign m_data = out_reg;

endmodule

// File: rtl/pbcw_controller.sv
// Controller: clearing pass, item sequencing and result valid.
`timescale 1ns / 1ps
module pbcw_controller
    import pbcw_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_UPDATE} state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg;

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.capture = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_UPDATE;
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_UPDATE) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    a_update_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_UPDATE |-> !m_valid_reg) else $error("result overwritten");
    a_update_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_UPDATE |=> m_valid_reg) else $error("result lost");
    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_READ) else $error("accept not sequenced");

endmodule

// File: rtl/pileup_base_count_window.sv
// Top level of the pileup base-count window.
`timescale 1ns / 1ps
// Keeps a circular window of genome positions with per-position base counters.
// Input words (s_valid/s_ready/s_data) carry one event each: base observation,
// read end or retire of the oldest position. Each accepted word yields exactly
// one result word on m_valid/m_ready/m_data, in order.
// The quality cutoff is written via cfg_valid/cfg_ready/cfg_data (cfg_ready is
// always high); the user must do so only while idle, not enforced by the block.
// A result shows on m_valid after its word passes states S_READ and S_UPDATE,
// and a new word is taken only once the previous one is through the registered
// read, modify and write of one slot in the slot memory.
// After reset the block clears all 2^WINDOW_LOG2 slots, one per cycle, and takes
// no input word until that pass ends.
// While the receiver stalls, the result holds in the output register and the
// next input word waits in front of s_ready.
module pileup_base_count_window
    import pbcw_pkg::*;
#(
    parameter int WINDOW_LOG2 = WINDOW_LOG2_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_word_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    pbcw_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    pbcw_datapath #(
        .WINDOW_LOG2 (WINDOW_LOG2),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_data   (s_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_data   (m_data)
    );

endmodule
